// File: rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

    localparam int RCP_W = 32;
    localparam int CH_W = 8;
    localparam int HUE_W = 15;
    localparam int SAT_W = 17;
    localparam int SAT_NUM_W = 24;
    localparam int HUE_NUM_W = 20;
    localparam int HUE_Q_W = 12;
    localparam int SIDE_DLY = 4;

    localparam logic [HUE_Q_W-1:0] HUE_SIXTH = 12'd3840;
    localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

    typedef enum logic [1:0] {
        SEC_RED = 2'd0,
        SEC_GRN = 2'd1,
        SEC_BLU = 2'd2
    } t_sector;

    typedef struct packed {
        t_sector sector;
        logic neg;
        logic [CH_W-1:0] value;
    } t_side;

endpackage

// File: rtl/core/rgbhsv_div.sv
module rgbhsv_div
    import rgbhsv_pkg::*;
#(
    parameter int NUM_W = SAT_NUM_W,
    parameter int QUO_W = SAT_W
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [CH_W-1:0]  i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int PROD_W = NUM_W + RCP_W;

    // floor((2^32-1)/d); estimate is exact or one low
    logic [RCP_W-1:0] w_rcp [256];
    for (genvar Dv = 0; Dv < 256; Dv++) begin : g_rcp
        if (Dv == 0) begin : g_zero
            assign w_rcp[Dv] = '0;
        end else begin : g_val
            assign w_rcp[Dv] = RCP_W'(64'hFFFF_FFFF / Dv);
        end
    end

    logic [NUM_W-1:0] r_a_num;
    logic [CH_W-1:0]  r_a_den;
    logic [RCP_W-1:0] r_a_rcp;
    logic [NUM_W-1:0] r_b_num;
    logic [CH_W-1:0]  r_b_den;
    logic [QUO_W-1:0] r_b_q;
    logic [NUM_W-1:0] r_c_rem;
    logic [CH_W-1:0]  r_c_den;
    logic [QUO_W-1:0] r_c_q;
    logic [QUO_W-1:0] r_d_q;

    logic [PROD_W-1:0] w_prod;
    logic [NUM_W-1:0]  w_qd;
    logic              w_inc;

    assign w_prod = PROD_W'(r_a_num) * PROD_W'(r_a_rcp);
    assign w_qd   = NUM_W'(r_b_q) * NUM_W'(r_b_den);
    assign w_inc  = r_c_rem >= NUM_W'(r_c_den);

    always_ff @(posedge i_clk) begin
        r_a_num <= i_num;
        r_a_den <= i_den;
        r_a_rcp <= w_rcp[i_den];

        r_b_num <= r_a_num;
        r_b_den <= r_a_den;
        r_b_q   <= w_prod[RCP_W +: QUO_W];

        r_c_rem <= r_b_num - w_qd;
        r_c_den <= r_b_den;
        r_c_q   <= r_b_q;

        if (r_c_den == '0) begin
            r_d_q <= '0;
        end else begin
            r_d_q <= r_c_q + QUO_W'(w_inc);
        end
    end

    assign o_quo = r_d_q;

endmodule

// File: rtl/core/rgb_to_hsv_convert_unit.sv
// RGB to HSV converter. One pixel request is taken every clock cycle; busy
// stays low except during reset and the first cycle after it. Each request
// gives one result, shown for a single cycle with o_done high, and the
// receiver cannot stall it. Each request passes the max/min stage, the two
// reciprocal-multiply dividers (table lookup, multiply, remainder, correct)
// and then the output register. Hue is in 1/64 degree,
// saturation has 16 fractional bits, value is the largest channel.
module rgb_to_hsv_convert_unit
    import rgbhsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CH_W-1:0]  i_red_in,
    input  logic [CH_W-1:0]  i_green_in,
    input  logic [CH_W-1:0]  i_blue_in,
    output logic             o_done,
    output logic [HUE_W-1:0] o_hue_out,
    output logic [SAT_W-1:0] o_sat_out,
    output logic [CH_W-1:0]  o_value_out
);

    logic r_rdy;

    logic [CH_W-1:0] w_max;
    logic [CH_W-1:0] w_min;
    t_sector         w_sec;
    logic [CH_W-1:0] w_pos;
    logic [CH_W-1:0] w_sub;
    logic            w_neg;

    logic            r1_vld;
    logic [CH_W-1:0] r1_diff;
    logic [CH_W-1:0] r1_absd;
    t_side           r1_side;

    logic [SIDE_DLY-1:0] r_vld_dly;
    t_side               r_side_dly [SIDE_DLY];

    logic [SAT_W-1:0]   w_sat_q;
    logic [HUE_Q_W-1:0] w_hue_q;
    logic [HUE_W-1:0]   w_hq;
    logic [HUE_W-1:0]   n_hue;
    t_side              w_side;

    logic             r_done;
    logic [HUE_W-1:0] r_hue;
    logic [SAT_W-1:0] r_sat;
    logic [CH_W-1:0]  r_val;

    assign busy = ~r_rdy;

    always_comb begin
        w_max = i_red_in;
        w_min = i_red_in;
        if (i_green_in > w_max) w_max = i_green_in;
        if (i_blue_in > w_max) w_max = i_blue_in;
        if (i_green_in < w_min) w_min = i_green_in;
        if (i_blue_in < w_min) w_min = i_blue_in;
        if (i_red_in >= i_green_in && i_red_in >= i_blue_in) begin
            w_sec = SEC_RED;
            w_pos = i_green_in;
            w_sub = i_blue_in;
        end else if (i_green_in >= i_blue_in) begin
            w_sec = SEC_GRN;
            w_pos = i_blue_in;
            w_sub = i_red_in;
        end else begin
            w_sec = SEC_BLU;
            w_pos = i_red_in;
            w_sub = i_green_in;
        end
        w_neg = w_pos < w_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy     <= 1'b0;
            r1_vld    <= 1'b0;
            r_vld_dly <= '0;
            r_done    <= 1'b0;
        end else begin
            r_rdy     <= 1'b1;
            r1_vld    <= start & r_rdy;
            r_vld_dly <= {r_vld_dly[SIDE_DLY-2:0], r1_vld};
            r_done    <= r_vld_dly[SIDE_DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_diff <= w_max - w_min;
        r1_absd <= w_neg ? (w_sub - w_pos) : (w_pos - w_sub);
        r1_side <= '{sector: w_sec, neg: w_neg, value: w_max};
        r_side_dly[0] <= r1_side;
        for (int i = 1; i < SIDE_DLY; i++) begin
            r_side_dly[i] <= r_side_dly[i-1];
        end
    end

    rgbhsv_div #(
        .NUM_W(SAT_NUM_W),
        .QUO_W(SAT_W)
    ) u_sat_div (
        .i_clk(i_clk),
        .i_num({r1_diff, 16'd0}),
        .i_den(r1_side.value),
        .o_quo(w_sat_q)
    );

    rgbhsv_div #(
        .NUM_W(HUE_NUM_W),
        .QUO_W(HUE_Q_W)
    ) u_hue_div (
        .i_clk(i_clk),
        .i_num(HUE_NUM_W'(HUE_SIXTH) * HUE_NUM_W'(r1_absd)),
        .i_den(r1_diff),
        .o_quo(w_hue_q)
    );

    assign w_side = r_side_dly[SIDE_DLY-1];
    assign w_hq   = HUE_W'(w_hue_q);

    always_comb begin
        case (w_side.sector)
            SEC_RED: begin
                if (w_side.neg && w_hq != '0) n_hue = HUE_FULL - w_hq;
                else n_hue = w_hq;
            end
            SEC_GRN: n_hue = w_side.neg ? (HUE_GREEN - w_hq) : (HUE_GREEN + w_hq);
            SEC_BLU: n_hue = w_side.neg ? (HUE_BLUE - w_hq) : (HUE_BLUE + w_hq);
            default: n_hue = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hue <= n_hue;
        r_sat <= w_sat_q;
        r_val <= w_side.value;
    end

    assign o_done      = r_done;
    assign o_hue_out   = r_hue;
    assign o_sat_out   = r_sat;
    assign o_value_out = r_val;

endmodule

// File: rtl/core/rgbhsv_chk.sv
module rgbhsv_chk
    import rgbhsv_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input logic [HUE_W-1:0] o_hue_out,
    input logic [SAT_W-1:0] o_sat_out,
    input logic [CH_W-1:0]  o_value_out
);

    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_done)
        else $error("request without result");

    a_done_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 6))
        else $error("result without request");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hue_out < HUE_FULL && o_sat_out <= SAT_W'(17'h10000)))
        else $error("result out of range");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_value_out == '0) |-> (o_sat_out == '0 && o_hue_out == '0))
        else $error("black pixel result wrong");

endmodule

bind rgb_to_hsv_convert_unit rgbhsv_chk u_rgbhsv_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_done(o_done),
    .o_hue_out(o_hue_out),
    .o_sat_out(o_sat_out),
    .o_value_out(o_value_out)
);
